[sv/omfl_pkg.sv]
package omfl_pkg;

  localparam int SPAN_SLOTS = 16;
  localparam int SLOT_W     = (SPAN_SLOTS > 1) ? $clog2(SPAN_SLOTS) : 1;
  localparam int FILL_W     = $clog2(SPAN_SLOTS + 1);
  localparam int FRAME_W    = 48;
  localparam int COUNT_W    = 20;

  typedef enum logic [1:0] {
    OP_RECORD = 2'd0,
    OP_QUERY  = 2'd1,
    OP_CLEAR  = 2'd2
  } op_t;

  typedef enum logic [1:0] {
    STATUS_OK   = 2'd0,
    STATUS_MISS = 2'd1,
    STATUS_OVFL = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CHECK,
    ST_EVAL,
    ST_RESP
  } state_t;

  // one stored span
  typedef struct packed {
    logic [FRAME_W-1:0] output_start;
    logic [FRAME_W-1:0] media_start;
    logic [COUNT_W-1:0] media_count;
    logic [COUNT_W-1:0] hold_count;
  } span_t;

  // outcome of checking one span against the queried frame
  typedef struct packed {
    logic               hit;
    logic [FRAME_W-1:0] mapped;
    logic               holding;
  } match_t;

endpackage

[sv/omfl_span_ram.sv]
module omfl_span_ram (
  input  logic                            clk,
  input  logic                            wr_en,
  input  logic [omfl_pkg::SLOT_W-1:0]     wr_addr,
  input  omfl_pkg::span_t                 wr_data,
  input  logic                            rd_en,
  input  logic [omfl_pkg::SLOT_W-1:0]     rd_addr,
  output omfl_pkg::span_t                 rd_data
);

  omfl_pkg::span_t mem [omfl_pkg::SPAN_SLOTS];
  omfl_pkg::span_t rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // read data holds while no read is issued
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

[sv/omfl_span_eval.sv]
module omfl_span_eval (
  input  logic                             clk,
  input  logic                             cap,
  input  logic [omfl_pkg::FRAME_W-1:0]     frame,
  input  omfl_pkg::span_t                  span,
  output omfl_pkg::match_t                 match
);

  logic [omfl_pkg::FRAME_W:0]   diff;
  logic                         borrow_r;
  logic [omfl_pkg::FRAME_W-1:0] within_r;
  logic [omfl_pkg::COUNT_W:0]   len_r;
  logic                         below;
  logic [omfl_pkg::COUNT_W-1:0] step;

  // first half: offset into span and span length
  assign diff = {1'b0, frame} - {1'b0, span.output_start};

  always_ff @(posedge clk) begin
    if (cap) begin
      borrow_r <= diff[omfl_pkg::FRAME_W];
      within_r <= diff[omfl_pkg::FRAME_W-1:0];
      len_r    <= {1'b0, span.media_count} + {1'b0, span.hold_count};
    end
  end

  // second half: span end is inclusive, media position clamps at media count
  always_comb begin
    below         = within_r < omfl_pkg::FRAME_W'(span.media_count);
    step          = below ? within_r[omfl_pkg::COUNT_W-1:0] : span.media_count;
    match.hit     = !borrow_r && (within_r <= omfl_pkg::FRAME_W'(len_r));
    match.mapped  = span.media_start + omfl_pkg::FRAME_W'(step);
    match.holding = (span.hold_count != '0) && !below;
  end

endmodule

[sv/output_to_media_frame_ledger_unit.sv]
// output to media frame ledger
// keeps a ring of the most recent playback spans and maps output frames back
// to media frames
// input channel: in_valid / in_stall with op, span counts and query frame;
//   a word is taken only while the unit is idle
// result channel: out_valid / out_stall, one result word per input word,
//   always carrying both running totals after the item
// record, clear, unused op, frame zero and empty-ring queries go straight
//   to the result state, and raise out_valid when the result is loaded
// a query reads the span memory newest first; for each span one memory
//   read is followed by the compare and the media add, and at most 16
//   spans are visited before a hit or a miss is reported
// throughput: the next word is accepted the cycle after a result moves into
//   the output register; a held result does not block the next word
// reset (synchronous, rst_n low): ring empty, write slot and totals zero,
//   no result pending; span memory contents are not cleared
// receiver stall: the output register holds its word; one further result
//   waits inside until the register frees, then input stalls
module output_to_media_frame_ledger_unit (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [1:0]                       in_op,
  input  logic [omfl_pkg::COUNT_W-1:0]     in_span_media_frames,
  input  logic [omfl_pkg::COUNT_W-1:0]     in_span_hold_frames,
  input  logic [omfl_pkg::FRAME_W-1:0]     in_query_output_frame,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [1:0]                       out_status,
  output logic [omfl_pkg::FRAME_W-1:0]     out_mapped_media_frame,
  output logic                             out_is_holding,
  output logic [omfl_pkg::FRAME_W-1:0]     out_output_total,
  output logic [omfl_pkg::FRAME_W-1:0]     out_media_total
);

  localparam int SLOT_W  = omfl_pkg::SLOT_W;
  localparam int FILL_W  = omfl_pkg::FILL_W;
  localparam int FRAME_W = omfl_pkg::FRAME_W;
  localparam int COUNT_W = omfl_pkg::COUNT_W;

  omfl_pkg::state_t state_r, state_nxt;

  // ring bookkeeping and totals
  logic [FILL_W-1:0]  filled_r, filled_nxt;
  logic [SLOT_W-1:0]  wslot_r, wslot_nxt;
  logic [FRAME_W-1:0] out_tot_r, out_tot_nxt;
  logic [FRAME_W-1:0] med_tot_r, med_tot_nxt;

  // search walk
  logic [SLOT_W-1:0]  slot_r, slot_nxt;
  logic [FILL_W-1:0]  cnt_r, cnt_nxt;
  logic [FRAME_W-1:0] frame_r, frame_nxt;

  // staged result
  logic [1:0]         res_status_r, res_status_nxt;
  logic [FRAME_W-1:0] res_mapped_r, res_mapped_nxt;
  logic               res_hold_r, res_hold_nxt;

  // output register
  logic               out_valid_r, out_valid_nxt;
  logic [1:0]         out_status_r;
  logic [FRAME_W-1:0] out_mapped_r;
  logic               out_hold_r;
  logic [FRAME_W-1:0] out_otot_r;
  logic [FRAME_W-1:0] out_mtot_r;
  logic               out_load;

  // memory and compare
  logic               wr_en;
  omfl_pkg::span_t    wr_data;
  logic               rd_en;
  logic [SLOT_W-1:0]  rd_addr;
  omfl_pkg::span_t    rd_data;
  logic               cap;
  omfl_pkg::match_t   match;

  logic               accept;
  logic [COUNT_W:0]   span_len;
  logic [FRAME_W:0]   out_sum;
  logic [FRAME_W:0]   med_sum;
  logic [SLOT_W-1:0]  wslot_prev;
  logic [SLOT_W-1:0]  slot_prev;

  assign accept   = in_valid && !in_stall;
  assign in_stall = (state_r != omfl_pkg::ST_IDLE);

  // overflow check for a record: sums carry past bit 47
  assign span_len = {1'b0, in_span_media_frames} + {1'b0, in_span_hold_frames};
  assign out_sum  = {1'b0, out_tot_r} + (FRAME_W + 1)'(span_len);
  assign med_sum  = {1'b0, med_tot_r} + (FRAME_W + 1)'(in_span_media_frames);

  assign wslot_prev = (wslot_r == '0) ? SLOT_W'(omfl_pkg::SPAN_SLOTS - 1) : wslot_r - 1'b1;
  assign slot_prev  = (slot_r == '0) ? SLOT_W'(omfl_pkg::SPAN_SLOTS - 1) : slot_r - 1'b1;

  assign wr_data.output_start = out_tot_r;
  assign wr_data.media_start  = med_tot_r;
  assign wr_data.media_count  = in_span_media_frames;
  assign wr_data.hold_count   = in_span_hold_frames;

  // output register frees when empty or when its word is taken
  assign out_load = (state_r == omfl_pkg::ST_RESP) && (!out_valid_r || !out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= omfl_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt      = state_r;
    filled_nxt     = filled_r;
    wslot_nxt      = wslot_r;
    out_tot_nxt    = out_tot_r;
    med_tot_nxt    = med_tot_r;
    slot_nxt       = slot_r;
    cnt_nxt        = cnt_r;
    frame_nxt      = frame_r;
    res_status_nxt = res_status_r;
    res_mapped_nxt = res_mapped_r;
    res_hold_nxt   = res_hold_r;
    wr_en          = 1'b0;
    rd_en          = 1'b0;
    rd_addr        = slot_prev;
    cap            = 1'b0;

    case (state_r)
      omfl_pkg::ST_IDLE: begin
        if (accept) begin
          res_status_nxt = omfl_pkg::STATUS_OK;
          res_mapped_nxt = '0;
          res_hold_nxt   = 1'b0;
          state_nxt      = omfl_pkg::ST_RESP;
          case (in_op)
            omfl_pkg::OP_RECORD: begin
              if (span_len == '0) begin
                // empty span leaves everything as is
              end else if (out_sum[FRAME_W] || med_sum[FRAME_W]) begin
                res_status_nxt = omfl_pkg::STATUS_OVFL;
              end else begin
                wr_en       = 1'b1;
                wslot_nxt   = (wslot_r == SLOT_W'(omfl_pkg::SPAN_SLOTS - 1)) ?
                              '0 : wslot_r + 1'b1;
                if (filled_r < FILL_W'(omfl_pkg::SPAN_SLOTS)) begin
                  filled_nxt = filled_r + 1'b1;
                end
                out_tot_nxt = out_sum[FRAME_W-1:0];
                med_tot_nxt = med_sum[FRAME_W-1:0];
              end
            end
            omfl_pkg::OP_QUERY: begin
              if (in_query_output_frame == '0) begin
                // frame zero always maps to media zero
              end else if (filled_r == '0) begin
                res_status_nxt = omfl_pkg::STATUS_MISS;
              end else begin
                // start the walk at the newest span
                rd_en     = 1'b1;
                rd_addr   = wslot_prev;
                slot_nxt  = wslot_prev;
                cnt_nxt   = filled_r;
                frame_nxt = in_query_output_frame;
                state_nxt = omfl_pkg::ST_CHECK;
              end
            end
            omfl_pkg::OP_CLEAR: begin
              filled_nxt  = '0;
              wslot_nxt   = '0;
              out_tot_nxt = '0;
              med_tot_nxt = '0;
            end
            default: begin
              // unused op: plain echo of the totals
            end
          endcase
        end
      end

      omfl_pkg::ST_CHECK: begin
        cap       = 1'b1;
        state_nxt = omfl_pkg::ST_EVAL;
      end

      omfl_pkg::ST_EVAL: begin
        if (match.hit) begin
          res_status_nxt = omfl_pkg::STATUS_OK;
          res_mapped_nxt = match.mapped;
          res_hold_nxt   = match.holding;
          state_nxt      = omfl_pkg::ST_RESP;
        end else if (cnt_r == FILL_W'(1)) begin
          res_status_nxt = omfl_pkg::STATUS_MISS;
          state_nxt      = omfl_pkg::ST_RESP;
        end else begin
          // step to the next older span
          rd_en     = 1'b1;
          rd_addr   = slot_prev;
          slot_nxt  = slot_prev;
          cnt_nxt   = cnt_r - 1'b1;
          state_nxt = omfl_pkg::ST_CHECK;
        end
      end

      omfl_pkg::ST_RESP: begin
        if (out_load) begin
          state_nxt = omfl_pkg::ST_IDLE;
        end
      end

      default: begin
        state_nxt = omfl_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      filled_r  <= '0;
      wslot_r   <= '0;
      out_tot_r <= '0;
      med_tot_r <= '0;
    end else begin
      filled_r  <= filled_nxt;
      wslot_r   <= wslot_nxt;
      out_tot_r <= out_tot_nxt;
      med_tot_r <= med_tot_nxt;
    end
  end

  always_ff @(posedge clk) begin
    slot_r       <= slot_nxt;
    cnt_r        <= cnt_nxt;
    frame_r      <= frame_nxt;
    res_status_r <= res_status_nxt;
    res_mapped_r <= res_mapped_nxt;
    res_hold_r   <= res_hold_nxt;
  end

  // output register, totals are already updated when the result moves out
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_status_r <= res_status_r;
      out_mapped_r <= res_mapped_r;
      out_hold_r   <= res_hold_r;
      out_otot_r   <= out_tot_r;
      out_mtot_r   <= med_tot_r;
    end
  end

  assign out_valid              = out_valid_r;
  assign out_status             = out_status_r;
  assign out_mapped_media_frame = out_mapped_r;
  assign out_is_holding         = out_hold_r;
  assign out_output_total       = out_otot_r;
  assign out_media_total        = out_mtot_r;

  omfl_span_ram u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wslot_r),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  omfl_span_eval u_eval (
    .clk   (clk),
    .cap   (cap),
    .frame (frame_r),
    .span  (rd_data),
    .match (match)
  );

endmodule
